// ===== rtl/qdvt_pkg.sv =====
package qdvt_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int ACC_BITS      = 48;
  localparam int INTERVAL_BITS = 10;
  localparam int ALPHA_BITS    = 16;
  localparam int SPEED_BITS    = 14;
  localparam int OUT_POS_BITS  = 48;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS + 1;
  localparam int RAD_BITS  = 2 * DIFF_BITS;
  localparam int ROOT_BITS = DIFF_BITS;
  localparam int KEEP_BITS = ALPHA_BITS + 1;
  localparam int CNT_BITS  = $clog2((KEEP_BITS > DIFF_BITS) ? KEEP_BITS : DIFF_BITS);

  localparam int SPEED_MAX = 5792;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_I_OFFSET    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Q_OFFSET    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL_MS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LPF_ALPHA   = 2'd3;

  localparam logic [SAMPLE_BITS-1:0]   OFFSET_RST   = SAMPLE_BITS'(2048);
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RST = INTERVAL_BITS'(10);
  localparam logic [ALPHA_BITS-1:0]    ALPHA_RST    = ALPHA_BITS'(58982);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] i_sample;
    logic [SAMPLE_BITS-1:0] q_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0]   signed_speed;
    logic signed [OUT_POS_BITS-1:0] displacement;
    logic signed [OUT_POS_BITS-1:0] smoothed_displacement;
  } out_item_t;

endpackage

// ===== rtl/qdvt_isqrt.sv =====
module qdvt_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [qdvt_pkg::RAD_BITS-1:0]  radicand,
  output logic                           done,
  output logic [qdvt_pkg::ROOT_BITS-1:0] root
);

  localparam int RB   = qdvt_pkg::RAD_BITS;
  localparam int RTB  = qdvt_pkg::ROOT_BITS;
  localparam int REMW = RTB + 3;
  localparam int CB   = qdvt_pkg::CNT_BITS;

  logic            busy_r;
  logic            done_r;
  logic [CB-1:0]   cnt_r;
  logic [RB-1:0]   rad_r;
  logic [REMW-1:0] rem_r;
  logic [RTB-1:0]  root_r;

  logic [REMW-1:0] shifted;
  logic [REMW-1:0] trial;
  logic            fits;

  always_comb begin
    shifted = {rem_r[REMW-3:0], rad_r[RB-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    fits    = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CB'(RTB - 1);
      end else if (busy_r) begin
        // take two radicand bits per step
        rad_r  <= {rad_r[RB-3:0], 2'b00};
        rem_r  <= fits ? (shifted - trial) : shifted;
        root_r <= {root_r[RTB-2:0], fits};
        cnt_r  <= cnt_r - CB'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/quadrature_doppler_velocity_tracker.sv =====
// Quadrature Doppler velocity tracker. Each input transfer carries one I/Q pair in ADC counts;
// the block forms the change from the previous pair and the pair centered on i_offset/q_offset,
// takes speed as the floor square root of the squared change (negative when the rotation is
// reversed), integrates speed times interval_ms into a saturating position and smooths that
// position with a first-order low-pass filter whose keep factor lpf_alpha is Q0.16. One result
// leaves for every input; a new input is accepted only after the previous one has gone through
// the bit-serial products of the I/Q change, the two-bits-per-cycle square root and the
// bit-serial 17-step low-pass multiply. The result sits in an output register, so the next
// input is taken while it waits. Write the configuration registers only while the block is idle.
module quadrature_doppler_velocity_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qdvt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qdvt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [qdvt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qdvt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int S   = qdvt_pkg::SAMPLE_BITS;
  localparam int W   = qdvt_pkg::DIFF_BITS;
  localparam int PW  = qdvt_pkg::PROD_BITS;
  localparam int RB  = qdvt_pkg::RAD_BITS;
  localparam int RTB = qdvt_pkg::ROOT_BITS;
  localparam int A   = qdvt_pkg::ACC_BITS;
  localparam int KW  = qdvt_pkg::KEEP_BITS;
  localparam int AB  = qdvt_pkg::ALPHA_BITS;
  localparam int IB  = qdvt_pkg::INTERVAL_BITS;
  localparam int CB  = qdvt_pkg::CNT_BITS;
  localparam int SCL = W + IB + 2;

  localparam logic signed [A-1:0] POS_MAX = {1'b0, {(A-1){1'b1}}};
  localparam logic signed [A-1:0] POS_MIN = {1'b1, {(A-1){1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_SQRT  = 9'b000000100,
    ST_SCALE = 9'b000001000,
    ST_ACCUM = 9'b000010000,
    ST_DIFF  = 9'b000100000,
    ST_LPF   = 9'b001000000,
    ST_ROUND = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [S-1:0]  i_off_r, q_off_r;
  logic [IB-1:0] interval_r;
  logic [AB-1:0] alpha_r;
  logic [S-1:0]  prev_i_r, prev_q_r;

  logic signed [W-1:0]  di_r, dq_r;
  logic [W-1:0]         bdi_r, bdq_r, bci_r, bcq_r;
  logic signed [PW-1:0] mag_r, cross_r;
  logic [CB-1:0]        cnt_r;
  logic                 neg_r;

  logic signed [W:0]     speed_r;
  logic signed [SCL-1:0] scaled_r;
  logic signed [A-1:0]   pos_r, smooth_r;

  logic          up_r;
  logic [A-1:0]  m_r, p_r;
  logic [KW-1:0] k_r, low_r;
  logic [A:0]    step_r;

  logic                out_valid_r;
  qdvt_pkg::out_item_t out_data_r;

  logic signed [W-1:0]  di_in, dq_in, ci_in, cq_in;
  logic signed [PW-1:0] di_x, dq_x, sel_m, sel_c, mag_nxt, cross_nxt;
  logic                 first;
  logic                 sqrt_start, sqrt_done;
  logic [RTB-1:0]       sqrt_root;
  logic signed [A:0]    sum;
  logic signed [A-1:0]  pos_nxt;
  logic signed [A:0]    diff;
  logic [A:0]           dmag;
  logic [A:0]           lpf_sum;
  logic signed [A-1:0]  smooth_nxt;
  logic                 out_free;

  always_comb begin
    di_in = $signed({1'b0, in_data.i_sample}) - $signed({1'b0, prev_i_r});
    dq_in = $signed({1'b0, in_data.q_sample}) - $signed({1'b0, prev_q_r});
    ci_in = $signed({1'b0, in_data.i_sample}) - $signed({1'b0, i_off_r});
    cq_in = $signed({1'b0, in_data.q_sample}) - $signed({1'b0, q_off_r});
  end

  // MSB-first signed shift-and-add: the sign bit carries negative weight
  always_comb begin
    di_x      = PW'(di_r);
    dq_x      = PW'(dq_r);
    sel_m     = (bdi_r[W-1] ? di_x : '0) + (bdq_r[W-1] ? dq_x : '0);
    sel_c     = (bci_r[W-1] ? dq_x : '0) - (bcq_r[W-1] ? di_x : '0);
    first     = cnt_r == CB'(W - 1);
    mag_nxt   = first ? -sel_m : ((mag_r <<< 1) + sel_m);
    cross_nxt = first ? -sel_c : ((cross_r <<< 1) + sel_c);
  end

  assign sqrt_start = (state_r == ST_MUL) && (cnt_r == '0);

  qdvt_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (mag_nxt[RB-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    sum = (A+1)'(pos_r) + (A+1)'(scaled_r);
    if (sum[A] != sum[A-1]) begin
      pos_nxt = sum[A] ? POS_MIN : POS_MAX;
    end else begin
      pos_nxt = sum[A-1:0];
    end
    diff       = (A+1)'(pos_r) - (A+1)'(smooth_r);
    dmag       = diff[A] ? -diff : diff;
    lpf_sum    = {1'b0, p_r} + (k_r[0] ? {1'b0, m_r} : '0);
    smooth_nxt = up_r ? (smooth_r + step_r[A-1:0]) : (smooth_r - step_r[A-1:0]);
    out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_SQRT;
      ST_SQRT:  if (sqrt_done) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_LPF;
      ST_LPF:   if (cnt_r == '0) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_off_r     <= qdvt_pkg::OFFSET_RST;
      q_off_r     <= qdvt_pkg::OFFSET_RST;
      interval_r  <= qdvt_pkg::INTERVAL_RST;
      alpha_r     <= qdvt_pkg::ALPHA_RST;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      pos_r       <= '0;
      smooth_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          qdvt_pkg::CFG_I_OFFSET:    i_off_r    <= cfg_wdata[S-1:0];
          qdvt_pkg::CFG_Q_OFFSET:    q_off_r    <= cfg_wdata[S-1:0];
          qdvt_pkg::CFG_INTERVAL_MS: interval_r <= cfg_wdata[IB-1:0];
          qdvt_pkg::CFG_LPF_ALPHA:   alpha_r    <= cfg_wdata[AB-1:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            di_r     <= di_in;
            dq_r     <= dq_in;
            bdi_r    <= di_in;
            bdq_r    <= dq_in;
            bci_r    <= ci_in;
            bcq_r    <= cq_in;
            prev_i_r <= in_data.i_sample;
            prev_q_r <= in_data.q_sample;
            cnt_r    <= CB'(W - 1);
          end
        end
        ST_MUL: begin
          mag_r   <= mag_nxt;
          cross_r <= cross_nxt;
          bdi_r   <= {bdi_r[W-2:0], 1'b0};
          bdq_r   <= {bdq_r[W-2:0], 1'b0};
          bci_r   <= {bci_r[W-2:0], 1'b0};
          bcq_r   <= {bcq_r[W-2:0], 1'b0};
          cnt_r   <= cnt_r - CB'(1);
          if (cnt_r == '0) neg_r <= cross_nxt[PW-1];
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            speed_r <= neg_r ? -$signed({1'b0, sqrt_root}) : $signed({1'b0, sqrt_root});
          end
        end
        ST_SCALE: begin
          scaled_r <= SCL'(speed_r) * SCL'($signed({1'b0, interval_r}));
        end
        ST_ACCUM: begin
          pos_r <= pos_nxt;
        end
        ST_DIFF: begin
          up_r  <= !diff[A];
          m_r   <= dmag[A-1:0];
          k_r   <= {1'b1, {AB{1'b0}}} - {1'b0, alpha_r};
          p_r   <= '0;
          low_r <= '0;
          cnt_r <= CB'(KW - 1);
        end
        ST_LPF: begin
          // LSB-first multiply; low product bits shift out into low_r
          p_r   <= lpf_sum[A:1];
          low_r <= {lpf_sum[0], low_r[KW-1:1]};
          k_r   <= {1'b0, k_r[KW-1:1]};
          cnt_r <= cnt_r - CB'(1);
        end
        ST_ROUND: begin
          step_r <= {p_r, low_r[KW-1]} + (A+1)'(low_r[KW-2]);
        end
        ST_DONE: begin
          if (out_free) begin
            smooth_r                         <= smooth_nxt;
            out_data_r.signed_speed          <= qdvt_pkg::SPEED_BITS'(speed_r);
            out_data_r.displacement          <= qdvt_pkg::OUT_POS_BITS'(pos_r);
            out_data_r.smoothed_displacement <= qdvt_pkg::OUT_POS_BITS'(smooth_nxt);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/qdvt_checker.sv =====
module qdvt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qdvt_pkg::out_item_t out_data
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again in the cycle after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.signed_speed) <= qdvt_pkg::SPEED_MAX) &&
                  ($signed(out_data.signed_speed) >= -qdvt_pkg::SPEED_MAX))
    else $error("speed outside the square root range");

endmodule

bind quadrature_doppler_velocity_tracker qdvt_checker u_qdvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_quadrature_doppler_velocity_tracker.sv =====
`timescale 1ns / 100ps

module tb_quadrature_doppler_velocity_tracker;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          MAX_GAP     = 12;
  localparam int          SETTLE      = 60;
  localparam longint      POS_MAX     = (longint'(1) <<< (qdvt_pkg::ACC_BITS - 1)) - 1;
  localparam longint      POS_MIN     = -POS_MAX - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  qdvt_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  qdvt_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [qdvt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [qdvt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  int unsigned cycle_count    = 0;
  int          mismatch_count = 0;
  bit          no_idle        = 1'b0;

  // tracker copy: registers and state
  logic [qdvt_pkg::SAMPLE_BITS-1:0]   trk_i_offset = qdvt_pkg::OFFSET_RST;
  logic [qdvt_pkg::SAMPLE_BITS-1:0]   trk_q_offset = qdvt_pkg::OFFSET_RST;
  logic [qdvt_pkg::INTERVAL_BITS-1:0] trk_interval = qdvt_pkg::INTERVAL_RST;
  logic [qdvt_pkg::ALPHA_BITS-1:0]    trk_alpha    = qdvt_pkg::ALPHA_RST;
  logic [qdvt_pkg::SAMPLE_BITS-1:0]   trk_last_i   = '0;
  logic [qdvt_pkg::SAMPLE_BITS-1:0]   trk_last_q   = '0;
  longint                             trk_position = 0;
  longint                             trk_smooth   = 0;

  qdvt_pkg::out_item_t velocity_expected[$];

  quadrature_doppler_velocity_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint floor_root(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic qdvt_pkg::out_item_t track_sample(qdvt_pkg::in_item_t s);
    qdvt_pkg::out_item_t r;
    longint    di, dq, ci, cq, cross_prod, speed, step, gap_mag, keep, pos_next;
    bit        up;
    di = longint'(s.i_sample) - longint'(trk_last_i);
    dq = longint'(s.q_sample) - longint'(trk_last_q);
    ci = longint'(s.i_sample) - longint'(trk_i_offset);
    cq = longint'(s.q_sample) - longint'(trk_q_offset);
    cross_prod = dq * ci - di * cq;
    speed = floor_root(di * di + dq * dq);
    if (cross_prod < 0) begin
      speed = -speed;
    end
    step = speed * longint'(trk_interval);
    pos_next = trk_position + step;
    if (pos_next > POS_MAX) begin
      pos_next = POS_MAX;
    end else if (pos_next < POS_MIN) begin
      pos_next = POS_MIN;
    end
    trk_position = pos_next;
    keep = 65536 - longint'(trk_alpha);
    up = (trk_position >= trk_smooth);
    gap_mag = up ? trk_position - trk_smooth : trk_smooth - trk_position;
    step = keep * (gap_mag >>> 16) + ((keep * (gap_mag & 64'hFFFF) + 32768) >>> 16);
    trk_smooth = up ? trk_smooth + step : trk_smooth - step;
    trk_last_i = s.i_sample;
    trk_last_q = s.q_sample;
    r.signed_speed          = speed[qdvt_pkg::SPEED_BITS-1:0];
    r.displacement          = trk_position[qdvt_pkg::OUT_POS_BITS-1:0];
    r.smoothed_displacement = trk_smooth[qdvt_pkg::OUT_POS_BITS-1:0];
    return r;
  endfunction

  function automatic logic [qdvt_pkg::SAMPLE_BITS-1:0] clamp_sample(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 4095) begin
      return 12'd4095;
    end
    return v[qdvt_pkg::SAMPLE_BITS-1:0];
  endfunction

  task automatic send_sample(input logic [qdvt_pkg::SAMPLE_BITS-1:0] i_s,
                             input logic [qdvt_pkg::SAMPLE_BITS-1:0] q_s);
    qdvt_pkg::in_item_t item;
    int                 gap;
    item.i_sample = i_s;
    item.q_sample = q_s;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    velocity_expected.push_back(track_sample(item));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (velocity_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [qdvt_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [qdvt_pkg::CFG_DATA_BITS-1:0] value);
    case (idx)
      qdvt_pkg::CFG_I_OFFSET:    trk_i_offset = value[qdvt_pkg::SAMPLE_BITS-1:0];
      qdvt_pkg::CFG_Q_OFFSET:    trk_q_offset = value[qdvt_pkg::SAMPLE_BITS-1:0];
      qdvt_pkg::CFG_INTERVAL_MS: trk_interval = value[qdvt_pkg::INTERVAL_BITS-1:0];
      qdvt_pkg::CFG_LPF_ALPHA:   trk_alpha    = value[qdvt_pkg::ALPHA_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_reset_extremes();
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd2048, 12'd2048);
    send_sample(12'd2048, 12'd2048);
    send_sample(12'd3048, 12'd2048);
    send_sample(12'd2048, 12'd3048);
    send_sample(12'd1048, 12'd2048);
    send_sample(12'd2048, 12'd1048);
    send_sample(12'd1048, 12'd2048);
    send_sample(12'd2048, 12'd3048);
  endtask

  task automatic test_register_corners();
    wait_for_results();
    write_register(qdvt_pkg::CFG_INTERVAL_MS, 16'd0);
    write_register(qdvt_pkg::CFG_LPF_ALPHA, 16'd0);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd100, 12'd3000);
    wait_for_results();
    write_register(qdvt_pkg::CFG_INTERVAL_MS, 16'd1023);
    write_register(qdvt_pkg::CFG_LPF_ALPHA, 16'd65535);
    write_register(qdvt_pkg::CFG_I_OFFSET, 16'd0);
    write_register(qdvt_pkg::CFG_Q_OFFSET, 16'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd4095);
    wait_for_results();
    write_register(qdvt_pkg::CFG_I_OFFSET, 16'hF000 | 16'd4095);
    write_register(qdvt_pkg::CFG_Q_OFFSET, 16'hF000);
    write_register(qdvt_pkg::CFG_INTERVAL_MS, 16'd1000);
    write_register(qdvt_pkg::CFG_LPF_ALPHA, 16'd1);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd2000, 12'd2100);
  endtask

  task automatic randomize_registers();
    logic [qdvt_pkg::SAMPLE_BITS-1:0]   off;
    logic [qdvt_pkg::INTERVAL_BITS-1:0] iv;
    logic [qdvt_pkg::ALPHA_BITS-1:0]    alpha;
    for (int r = 0; r < 2; r++) begin
      case ($urandom_range(0, 3))
        0:       off = '0;
        1:       off = 12'd4095;
        2:       off = 12'd2048 + 12'($urandom_range(0, 64)) - 12'd32;
        default: off = 12'($urandom_range(0, 4095));
      endcase
      write_register(r == 0 ? qdvt_pkg::CFG_I_OFFSET : qdvt_pkg::CFG_Q_OFFSET,
                     {4'($urandom), off});
    end
    case ($urandom_range(0, 5))
      0:       iv = '0;
      1:       iv = 10'd1;
      2:       iv = 10'd1000;
      3:       iv = 10'd1023;
      default: iv = 10'($urandom_range(1, 1000));
    endcase
    write_register(qdvt_pkg::CFG_INTERVAL_MS, {6'($urandom), iv});
    case ($urandom_range(0, 4))
      0:       alpha = '0;
      1:       alpha = 16'hFFFF;
      2:       alpha = qdvt_pkg::ALPHA_RST + 16'($urandom_range(0, 256)) - 16'd128;
      default: alpha = 16'($urandom);
    endcase
    write_register(qdvt_pkg::CFG_LPF_ALPHA, alpha);
  endtask

  task automatic test_random_tracking(input int phases, input int per_phase);
    int  sent;
    int  burst;
    int  cx, cy;
    real theta, step_rad, radius;
    for (int p = 0; p < phases; p++) begin
      wait_for_results();
      randomize_registers();
      no_idle = (p % 4 == 2);
      sent = 0;
      while (sent < per_phase) begin
        if (p == 3 && sent > per_phase / 2 && sent < per_phase / 2 + 20) begin
          wait_for_results();
          sent = per_phase / 2 + 20;
        end
        if ($urandom_range(0, 9) < 8) begin
          // rotate around the configured offset or a random center, either direction
          cx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : int'(trk_i_offset);
          cy = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : int'(trk_q_offset);
          radius   = real'($urandom_range(1, 2047));
          theta    = real'($urandom_range(0, 6283)) / 1000.0;
          step_rad = real'($urandom_range(5, 1500)) / 1000.0;
          if ($urandom_range(0, 1) == 1) begin
            step_rad = -step_rad;
          end
          burst = $urandom_range(10, 60);
          for (int k = 0; k < burst; k++) begin
            send_sample(clamp_sample(cx + $rtoi(radius * $cos(theta))),
                        clamp_sample(cy + $rtoi(radius * $sin(theta))));
            theta = theta + step_rad;
          end
        end else begin
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++) begin
            send_sample(12'($urandom), 12'($urandom));
          end
        end
        sent += burst;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    qdvt_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (velocity_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: speed %0d disp %0d smooth %0d",
                   out_data.signed_speed, out_data.displacement,
                   out_data.smoothed_displacement);
        end
      end else begin
        want = velocity_expected.pop_front();
        if (out_data.signed_speed !== want.signed_speed ||
            out_data.displacement !== want.displacement ||
            out_data.smoothed_displacement !== want.smoothed_displacement) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d:", cycle_count);
            $display("  speed  exp %0d got %0d", want.signed_speed, out_data.signed_speed);
            $display("  disp   exp %0d got %0d", want.displacement, out_data.displacement);
            $display("  smooth exp %0d got %0d", want.smoothed_displacement,
                     out_data.smoothed_displacement);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_extremes();
    test_register_corners();
    test_random_tracking(13, 125);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && velocity_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qdvt_pkg.sv
rtl/qdvt_isqrt.sv
rtl/quadrature_doppler_velocity_tracker.sv
rtl/qdvt_checker.sv
bench/tb_quadrature_doppler_velocity_tracker.sv
